### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the ALU block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Check that an antecedent implies a consequent sequence
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/eba_pkg.sv
// ----------------------------------------------------------------------------
// eba_pkg
// Operation codes, flag positions and field widths of the 8-bit CPU ALU.
// ----------------------------------------------------------------------------
package eba_pkg;

    localparam int unsigned OP_W   = 5;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned FLAG_W = 4;
    localparam int unsigned BIDX_W = 3;

    // Flag bit positions
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    // Decimal adjust constants
    localparam logic [7:0] DAA_LIMIT = 8'h99;
    localparam logic [7:0] DAA_HI    = 8'h60;
    localparam logic [7:0] DAA_LO    = 8'h06;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 5'd0,
        OP_ADC     = 5'd1,
        OP_SUB     = 5'd2,
        OP_SBC     = 5'd3,
        OP_AND     = 5'd4,
        OP_XOR     = 5'd5,
        OP_OR      = 5'd6,
        OP_CP      = 5'd7,
        OP_INC     = 5'd8,
        OP_DEC     = 5'd9,
        OP_RLC     = 5'd10,
        OP_RRC     = 5'd11,
        OP_RL      = 5'd12,
        OP_RR      = 5'd13,
        OP_SLA     = 5'd14,
        OP_SRA     = 5'd15,
        OP_SWAP    = 5'd16,
        OP_SRL     = 5'd17,
        OP_BIT     = 5'd18,
        OP_RES     = 5'd19,
        OP_SET     = 5'd20,
        OP_DAA     = 5'd21,
        OP_CPL     = 5'd22,
        OP_SCF     = 5'd23,
        OP_CCF     = 5'd24,
        OP_RLCA    = 5'd25,
        OP_RRCA    = 5'd26,
        OP_RLA     = 5'd27,
        OP_RRA     = 5'd28,
        OP_ADD16   = 5'd29,
        OP_ADDSPE8 = 5'd30
    } t_op;

endpackage

### rtl/core/eight_bit_cpu_alu_with_flags.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags
// 8-bit CPU ALU with flag update, registered on input and output.
// ----------------------------------------------------------------------------
// A beat is taken on each clock edge where start is high; busy never rises,
// so one operation can enter every cycle. The accepting edge loads the input
// register, and the result register then loads from the ALU. The result
// then sits on the outputs for one cycle with o_done high. The receiver
// cannot stall the block and must take each result in the cycle it is shown.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eight_bit_cpu_alu_with_flags (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [eba_pkg::OP_W-1:0]   i_operation,
    input  logic [eba_pkg::BYTE_W-1:0] i_acc_value,
    input  logic [eba_pkg::BYTE_W-1:0] i_byte_operand,
    input  logic [eba_pkg::FLAG_W-1:0] i_flags_in,
    input  logic [eba_pkg::BIDX_W-1:0] i_bit_index,
    input  logic [eba_pkg::WORD_W-1:0] i_word_base,
    input  logic [eba_pkg::WORD_W-1:0] i_word_addend,
    output logic                       o_done,
    output logic [eba_pkg::BYTE_W-1:0] o_byte_result,
    output logic [eba_pkg::WORD_W-1:0] o_word_result,
    output logic [eba_pkg::FLAG_W-1:0] o_flags_out
);

    logic                       r_in_valid;
    logic [eba_pkg::OP_W-1:0]   r_operation;
    logic [eba_pkg::BYTE_W-1:0] r_acc_value;
    logic [eba_pkg::BYTE_W-1:0] r_byte_operand;
    logic [eba_pkg::FLAG_W-1:0] r_flags_in;
    logic [eba_pkg::BIDX_W-1:0] r_bit_index;
    logic [eba_pkg::WORD_W-1:0] r_word_base;
    logic [eba_pkg::WORD_W-1:0] r_word_addend;

    logic                       r_out_valid;
    logic [eba_pkg::BYTE_W-1:0] r_byte_result;
    logic [eba_pkg::WORD_W-1:0] r_word_result;
    logic [eba_pkg::FLAG_W-1:0] r_flags_out;

    logic [eba_pkg::BYTE_W-1:0] n_byte_result;
    logic [eba_pkg::WORD_W-1:0] n_word_result;
    logic [eba_pkg::FLAG_W-1:0] n_flags_out;

    logic                       accept;
    logic                       scf_in;
    logic                       carry_out;

    // Every cycle can take a new beat
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Input stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    // Capture the operand beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_operation    <= i_operation;
            r_acc_value    <= i_acc_value;
            r_byte_operand <= i_byte_operand;
            r_flags_in     <= i_flags_in;
            r_bit_index    <= i_bit_index;
            r_word_base    <= i_word_base;
            r_word_addend  <= i_word_addend;
        end
    end

    eba_alu u_alu (
        .i_operation    (r_operation),
        .i_acc_value    (r_acc_value),
        .i_byte_operand (r_byte_operand),
        .i_flags_in     (r_flags_in),
        .i_bit_index    (r_bit_index),
        .i_word_base    (r_word_base),
        .i_word_addend  (r_word_addend),
        .o_byte_result  (n_byte_result),
        .o_word_result  (n_word_result),
        .o_flags_out    (n_flags_out)
    );

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    // Load the result register from the ALU when the input stage is valid
    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_byte_result <= n_byte_result;
            r_word_result <= n_word_result;
            r_flags_out   <= n_flags_out;
        end
    end

    assign o_done        = r_out_valid;
    assign o_byte_result = r_byte_result;
    assign o_word_result = r_word_result;
    assign o_flags_out   = r_flags_out;

    // Terms for the set-carry check
    assign scf_in    = (i_operation == eba_pkg::OP_SCF);
    assign carry_out = o_flags_out[eba_pkg::FLAG_C];

    // Each accepted beat yields a strobe through the input and result registers
    `ASSERT_IMPLY(a_accept_done, i_clk, i_rst_n, accept, ##2 o_done)

    // No strobe without an accepted input beat behind it
    `ASSERT_IMPLY(a_done_origin, i_clk, i_rst_n, o_done, $past(accept, 2))

    // Set carry always leaves carry high
    `ASSERT_IMPLY(a_scf_carry, i_clk, i_rst_n, o_done && $past(scf_in, 2), carry_out)

endmodule

### rtl/core/eba_alu.sv
// ----------------------------------------------------------------------------
// eba_alu
// Combinational datapath: byte result, word result and new flags for one op.
// ----------------------------------------------------------------------------
module eba_alu (
    input  logic [eba_pkg::OP_W-1:0]   i_operation,
    input  logic [eba_pkg::BYTE_W-1:0] i_acc_value,
    input  logic [eba_pkg::BYTE_W-1:0] i_byte_operand,
    input  logic [eba_pkg::FLAG_W-1:0] i_flags_in,
    input  logic [eba_pkg::BIDX_W-1:0] i_bit_index,
    input  logic [eba_pkg::WORD_W-1:0] i_word_base,
    input  logic [eba_pkg::WORD_W-1:0] i_word_addend,
    output logic [eba_pkg::BYTE_W-1:0] o_byte_result,
    output logic [eba_pkg::WORD_W-1:0] o_word_result,
    output logic [eba_pkg::FLAG_W-1:0] o_flags_out
);

    logic [7:0]  a;
    logic [7:0]  v;
    logic        cin;
    logic        f_z;
    logic        f_n;
    logic        f_h;
    logic        f_c;
    eba_pkg::t_op op;

    logic        use_c;
    logic [8:0]  add_sum;
    logic [4:0]  add_half;
    logic [8:0]  sub_diff;
    logic [4:0]  sub_half;

    logic [7:0]  shf_r;
    logic        shf_c;

    logic        daa_lo;
    logic        daa_hi;
    logic [7:0]  daa_adj;
    logic [7:0]  daa_r;

    logic [16:0] w16_sum;
    logic [12:0] w16_half;
    logic [15:0] sp_sum;
    logic [4:0]  sp_half;
    logic [8:0]  sp_low;

    assign a   = i_acc_value;
    assign v   = i_byte_operand;
    assign cin = i_flags_in[eba_pkg::FLAG_C];
    assign f_z = i_flags_in[eba_pkg::FLAG_Z];
    assign f_n = i_flags_in[eba_pkg::FLAG_N];
    assign f_h = i_flags_in[eba_pkg::FLAG_H];
    assign f_c = cin;
    assign op  = eba_pkg::t_op'(i_operation);

    // 8-bit add and subtract with optional carry in
    assign use_c    = cin & ((op == eba_pkg::OP_ADC) | (op == eba_pkg::OP_SBC));
    assign add_sum  = {1'b0, a} + {1'b0, v} + {8'd0, use_c};
    assign add_half = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, use_c};
    assign sub_diff = {1'b0, a} - {1'b0, v} - {8'd0, use_c};
    assign sub_half = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, use_c};

    // Rotates and shifts of the operand byte
    always_comb begin
        shf_r = v;
        shf_c = 1'b0;
        case (op)
            eba_pkg::OP_RLC, eba_pkg::OP_RLCA: begin
                shf_r = {v[6:0], v[7]};
                shf_c = v[7];
            end
            eba_pkg::OP_RRC, eba_pkg::OP_RRCA: begin
                shf_r = {v[0], v[7:1]};
                shf_c = v[0];
            end
            eba_pkg::OP_RL, eba_pkg::OP_RLA: begin
                shf_r = {v[6:0], cin};
                shf_c = v[7];
            end
            eba_pkg::OP_RR, eba_pkg::OP_RRA: begin
                shf_r = {cin, v[7:1]};
                shf_c = v[0];
            end
            eba_pkg::OP_SLA: begin
                shf_r = {v[6:0], 1'b0};
                shf_c = v[7];
            end
            eba_pkg::OP_SRA: begin
                shf_r = {v[7], v[7:1]};
                shf_c = v[0];
            end
            eba_pkg::OP_SWAP: begin
                shf_r = {v[3:0], v[7:4]};
                shf_c = 1'b0;
            end
            eba_pkg::OP_SRL: begin
                shf_r = {1'b0, v[7:1]};
                shf_c = v[0];
            end
            default: begin
                shf_r = v;
                shf_c = 1'b0;
            end
        endcase
    end

    // Decimal adjust after add or subtract
    assign daa_lo  = f_n ? f_h : (f_h | (a[3:0] > 4'd9));
    assign daa_hi  = f_n ? f_c : (f_c | (a > eba_pkg::DAA_LIMIT));
    assign daa_adj = (daa_hi ? eba_pkg::DAA_HI : 8'd0) | (daa_lo ? eba_pkg::DAA_LO : 8'd0);
    assign daa_r   = f_n ? (a - daa_adj) : (a + daa_adj);

    // 16-bit adds
    assign w16_sum  = {1'b0, i_word_base} + {1'b0, i_word_addend};
    assign w16_half = {1'b0, i_word_base[11:0]} + {1'b0, i_word_addend[11:0]};
    assign sp_sum   = i_word_base + {{8{v[7]}}, v};
    assign sp_half  = {1'b0, i_word_base[3:0]} + {1'b0, v[3:0]};
    assign sp_low   = {1'b0, i_word_base[7:0]} + {1'b0, v};

    // Select result and flags per operation
    always_comb begin
        o_byte_result = a;
        o_word_result = '0;
        o_flags_out   = i_flags_in;
        case (op)
            eba_pkg::OP_ADD, eba_pkg::OP_ADC: begin
                o_byte_result = add_sum[7:0];
                o_flags_out   = {add_sum[7:0] == 8'd0, 1'b0, add_half[4], add_sum[8]};
            end
            eba_pkg::OP_SUB, eba_pkg::OP_SBC: begin
                o_byte_result = sub_diff[7:0];
                o_flags_out   = {sub_diff[7:0] == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
            end
            eba_pkg::OP_CP: begin
                o_flags_out = {sub_diff[7:0] == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
            end
            eba_pkg::OP_AND: begin
                o_byte_result = a & v;
                o_flags_out   = {(a & v) == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            eba_pkg::OP_XOR: begin
                o_byte_result = a ^ v;
                o_flags_out   = {(a ^ v) == 8'd0, 3'b000};
            end
            eba_pkg::OP_OR: begin
                o_byte_result = a | v;
                o_flags_out   = {(a | v) == 8'd0, 3'b000};
            end
            eba_pkg::OP_INC: begin
                o_byte_result = v + 8'd1;
                o_flags_out   = {v == 8'hFF, 1'b0, v[3:0] == 4'hF, f_c};
            end
            eba_pkg::OP_DEC: begin
                o_byte_result = v - 8'd1;
                o_flags_out   = {v == 8'h01, 1'b1, v[3:0] == 4'h0, f_c};
            end
            eba_pkg::OP_RLC, eba_pkg::OP_RRC, eba_pkg::OP_RL, eba_pkg::OP_RR,
            eba_pkg::OP_SLA, eba_pkg::OP_SRA, eba_pkg::OP_SWAP, eba_pkg::OP_SRL: begin
                o_byte_result = shf_r;
                o_flags_out   = {shf_r == 8'd0, 2'b00, shf_c};
            end
            eba_pkg::OP_RLCA, eba_pkg::OP_RRCA, eba_pkg::OP_RLA, eba_pkg::OP_RRA: begin
                o_byte_result = shf_r;
                o_flags_out   = {3'b000, shf_c};
            end
            eba_pkg::OP_BIT: begin
                o_flags_out = {~v[i_bit_index], 1'b0, 1'b1, f_c};
            end
            eba_pkg::OP_RES: begin
                o_byte_result = v & ~(8'd1 << i_bit_index);
            end
            eba_pkg::OP_SET: begin
                o_byte_result = v | (8'd1 << i_bit_index);
            end
            eba_pkg::OP_DAA: begin
                o_byte_result = daa_r;
                o_flags_out   = {daa_r == 8'd0, f_n, 1'b0, daa_hi};
            end
            eba_pkg::OP_CPL: begin
                o_byte_result = ~a;
                o_flags_out   = {f_z, 1'b1, 1'b1, f_c};
            end
            eba_pkg::OP_SCF: begin
                o_flags_out = {f_z, 2'b00, 1'b1};
            end
            eba_pkg::OP_CCF: begin
                o_flags_out = {f_z, 2'b00, ~f_c};
            end
            eba_pkg::OP_ADD16: begin
                o_word_result = w16_sum[15:0];
                o_flags_out   = {f_z, 1'b0, w16_half[12], w16_sum[16]};
            end
            eba_pkg::OP_ADDSPE8: begin
                o_word_result = sp_sum;
                o_flags_out   = {2'b00, sp_half[4], sp_low[8]};
            end
            default: begin
                o_byte_result = a;
                o_word_result = '0;
                o_flags_out   = i_flags_in;
            end
        endcase
    end

endmodule
